>>> src/csort_pkg.sv
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types for the stable counting sort: controller states, the command
// group from controller to datapath and the status group coming back.
// ----------------------------------------------------------------------------
package csort_pkg;

  typedef enum logic [14:0] {
    S_LOAD      = 15'h0001,
    S_CHECK     = 15'h0002,
    S_CLEAR     = 15'h0004,
    S_HIST_RD   = 15'h0008,
    S_HIST_BIN  = 15'h0010,
    S_HIST_WR   = 15'h0020,
    S_PFX_RD    = 15'h0040,
    S_PFX_WR    = 15'h0080,
    S_PLACE_RD  = 15'h0100,
    S_PLACE_BIN = 15'h0200,
    S_PLACE_WR  = 15'h0400,
    S_OUT_RD    = 15'h0800,
    S_OUT_LD    = 15'h1000,
    S_OUT_WAIT  = 15'h2000,
    S_ERR_WAIT  = 15'h4000
  } state_t;

  typedef struct packed {
    logic load;
    logic run_clr;
    logic idx_clr;
    logic idx_top;
    logic idx_inc;
    logic idx_dec;
    logic item_rd;
    logic bin_rd_item;
    logic bin_rd_idx;
    logic bin_clr_wr;
    logic bin_inc_wr;
    logic acc_clr;
    logic pfx_wr;
    logic place_wr;
    logic sorted_rd;
    logic out_load;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic span_bad;
    logic bin_end;
    logic item_end;
    logic at_zero;
  } status_t;

endpackage

>>> src/csort_if.sv
// ----------------------------------------------------------------------------
// csort_if
// Handshake channels of the sort: input beats carry one value and a last
// mark, result beats carry one sorted value with run flags.
// ----------------------------------------------------------------------------
interface csort_in_if #(parameter int VALUE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface csort_out_if #(parameter int VALUE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sorted_value;
  logic                         last_res;
  logic                         span_error;
  logic                         items_dropped;

  modport source (output valid, sorted_value, last_res, span_error, items_dropped,
                  input ready);
  modport sink (input valid, sorted_value, last_res, span_error, items_dropped,
                output ready);
endinterface

>>> src/csort_ctrl.sv
// ----------------------------------------------------------------------------
// csort_ctrl
// Sequencer for the sort: load, span check, bin clear, histogram, prefix sum,
// right-to-left placement and result output.
// ----------------------------------------------------------------------------
module csort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output csort_pkg::cmd_t    cmd,
  input  csort_pkg::status_t stat
);
  import csort_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT_WAIT) || (state == S_ERR_WAIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.span_bad) begin
          cmd.out_err = 1'b1;
          state_next  = S_ERR_WAIT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.bin_clr_wr = 1'b1;
        if (stat.bin_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_HIST_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_HIST_RD: begin
        cmd.item_rd = 1'b1;
        state_next  = S_HIST_BIN;
      end
      S_HIST_BIN: begin
        cmd.bin_rd_item = 1'b1;
        state_next      = S_HIST_WR;
      end
      S_HIST_WR: begin
        cmd.bin_inc_wr = 1'b1;
        if (stat.item_end) begin
          cmd.idx_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          state_next  = S_PFX_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_HIST_RD;
        end
      end
      S_PFX_RD: begin
        cmd.bin_rd_idx = 1'b1;
        state_next     = S_PFX_WR;
      end
      S_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        if (stat.bin_end) begin
          cmd.idx_top = 1'b1;
          state_next  = S_PLACE_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_PFX_RD;
        end
      end
      S_PLACE_RD: begin
        cmd.item_rd = 1'b1;
        state_next  = S_PLACE_BIN;
      end
      S_PLACE_BIN: begin
        cmd.bin_rd_item = 1'b1;
        state_next      = S_PLACE_WR;
      end
      S_PLACE_WR: begin
        cmd.place_wr = 1'b1;
        if (stat.at_zero) begin
          state_next = S_OUT_RD;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_PLACE_RD;
        end
      end
      S_OUT_RD: begin
        cmd.sorted_rd = 1'b1;
        state_next    = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          if (stat.item_end) begin
            cmd.run_clr = 1'b1;
            state_next  = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_OUT_RD;
          end
        end
      end
      S_ERR_WAIT: begin
        if (out_ready) begin
          cmd.run_clr = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

>>> src/csort_dp.sv
// ----------------------------------------------------------------------------
// csort_dp
// Datapath of the sort: item, bin and sorted memories, run statistics, the
// shared walk index, prefix accumulator and the result register.
// ----------------------------------------------------------------------------
module csort_dp #(
  parameter int MAX_ITEMS  = 64,
  parameter int COUNT_BINS = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  csort_pkg::cmd_t              cmd,
  output csort_pkg::status_t           stat,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic signed [VALUE_BITS-1:0] res_value,
  output logic                         res_last,
  output logic                         res_span_error,
  output logic                         res_dropped
);
  import csort_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int BIN_W = $clog2(COUNT_BINS);
  localparam int IW    = (BIN_W > IDX_W) ? BIN_W : IDX_W;
  localparam int DW    = VALUE_BITS + 1;
  localparam int SPW   = VALUE_BITS + 18;

  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic signed [VALUE_BITS-1:0] item_mem [MAX_ITEMS];
  logic signed [VALUE_BITS-1:0] sorted_mem [MAX_ITEMS];
  logic [CNT_W-1:0]             bin_mem [COUNT_BINS];

  logic [CNT_W-1:0]             count;
  logic signed [VALUE_BITS-1:0] running_min;
  logic signed [VALUE_BITS-1:0] running_max;
  logic                         overflow;
  logic [IW-1:0]                idx;
  logic [CNT_W-1:0]             acc;
  logic [CNT_W-1:0]             acc_next;
  logic signed [VALUE_BITS-1:0] item_q;
  logic signed [VALUE_BITS-1:0] sorted_q;
  logic [CNT_W-1:0]             bin_q;
  logic [BIN_W-1:0]             bin_sel;

  logic                         has_room;
  logic [DW-1:0]                span_diff;
  logic [DW-1:0]                item_diff;
  logic signed [SPW-1:0]        span_full;
  logic [BIN_W-1:0]             item_bin;
  logic [CNT_W-1:0]             pos;
  logic                         bin_we;
  logic [BIN_W-1:0]             bin_wa;
  logic [CNT_W-1:0]             bin_wd;

  assign has_room  = (count < CNT_W'(MAX_ITEMS));
  assign span_diff = DW'(running_max) - DW'(running_min);
  assign item_diff = DW'(item_q) - DW'(running_min);
  assign item_bin  = BIN_W'(item_diff);
  assign span_full = SPW'(running_max) - SPW'(running_min) + SPW'(1);
  assign acc_next  = acc + bin_q;
  assign pos       = bin_q - CNT_W'(1);

  assign stat.span_bad = (span_full > SPW'(COUNT_BINS)) || (span_full < SPW'(1));
  assign stat.bin_end  = (idx == IW'(span_diff));
  assign stat.item_end = (idx == IW'(count - CNT_W'(1)));
  assign stat.at_zero  = (idx == '0);

  // run statistics
  always_ff @(posedge clk) begin
    if (rst || cmd.run_clr) begin
      count       <= '0;
      running_min <= VMAX;
      running_max <= VMIN;
      overflow    <= 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        count <= count + CNT_W'(1);
        if (value < running_min) running_min <= value;
        if (value > running_max) running_max <= value;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // walk index and prefix accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_top) begin
      idx <= IW'(count - CNT_W'(1));
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.pfx_wr) begin
      acc <= acc_next;
    end
  end

  // item memory
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) item_mem[IDX_W'(count)] <= value;
    if (cmd.item_rd) item_q <= item_mem[IDX_W'(idx)];
  end

  // bin memory
  always_comb begin
    bin_we = 1'b0;
    bin_wa = BIN_W'(idx);
    bin_wd = '0;
    if (cmd.bin_clr_wr) begin
      bin_we = 1'b1;
    end else if (cmd.bin_inc_wr) begin
      bin_we = 1'b1;
      bin_wa = bin_sel;
      bin_wd = bin_q + CNT_W'(1);
    end else if (cmd.pfx_wr) begin
      bin_we = 1'b1;
      bin_wd = acc_next;
    end else if (cmd.place_wr) begin
      bin_we = 1'b1;
      bin_wa = bin_sel;
      bin_wd = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    if (cmd.bin_rd_item) begin
      bin_q   <= bin_mem[item_bin];
      bin_sel <= item_bin;
    end else if (cmd.bin_rd_idx) begin
      bin_q <= bin_mem[BIN_W'(idx)];
    end
  end

  // sorted memory
  always_ff @(posedge clk) begin
    if (cmd.place_wr) sorted_mem[IDX_W'(pos)] <= item_q;
    if (cmd.sorted_rd) sorted_q <= sorted_mem[IDX_W'(idx)];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      res_value      <= '0;
      res_last       <= 1'b1;
      res_span_error <= 1'b1;
      res_dropped    <= overflow;
    end else if (cmd.out_load) begin
      res_value      <= sorted_q;
      res_last       <= stat.item_end;
      res_span_error <= 1'b0;
      res_dropped    <= overflow;
    end
  end

endmodule

>>> src/counting_sort_stable.sv
// ----------------------------------------------------------------------------
// counting_sort_stable
// Stable counting sort over a run of signed values ended by a last beat.
//
//   channel | dir | payload                                          | end
//   in      | in  | value, last                                      | last
//   out     | out | sorted_value, last_res, span_error, items_dropped | last_res
//
// Loading takes one input beat per cycle; in.ready is low from the last beat
// until the final result beat of the run is taken.
// For a run of n stored items with span s = max - min + 1, the sequencer
// then clears s bins, builds the histogram over the n items, sums the s bins
// into prefix positions, places the items right to left and outputs them.
// A span error run gives a single result beat with last_res and span_error.
// Output stalls hold the result register and the sequencer; rst is synchronous.
// ----------------------------------------------------------------------------
module counting_sort_stable #(
  parameter int MAX_ITEMS  = 64,
  parameter int COUNT_BINS = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  csort_in_if.sink    in,
  csort_out_if.source out
);
  import csort_pkg::*;

  cmd_t    cmd;
  status_t stat;

  csort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_last   (in.last),
    .in_ready  (in.ready),
    .out_ready (out.ready),
    .out_valid (out.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  csort_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .COUNT_BINS (COUNT_BINS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .value          (in.value),
    .res_value      (out.sorted_value),
    .res_last       (out.last_res),
    .res_span_error (out.span_error),
    .res_dropped    (out.items_dropped)
  );

endmodule

>>> src/csort_checker.sv
// ----------------------------------------------------------------------------
// csort_checker
// Port-level checks for the stable counting sort, bound to the top level.
// ----------------------------------------------------------------------------
module csort_checker #(
  parameter int VALUE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_last,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] sorted_value,
  input logic                  last_res,
  input logic                  span_error,
  input logic                  items_dropped
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value) &&
      $stable(last_res) && $stable(span_error) && $stable(items_dropped))
    else $error("stalled result beat changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && span_error |-> last_res && (sorted_value == '0))
    else $error("span error beat malformed");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_res |=> in_ready)
    else $error("input not reopened after run");

  a_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input still open after last beat");

endmodule

bind counting_sort_stable csort_checker #(.VALUE_BITS(VALUE_BITS)) u_csort_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in.valid),
  .in_ready      (in.ready),
  .in_last       (in.last),
  .out_valid     (out.valid),
  .out_ready     (out.ready),
  .sorted_value  (out.sorted_value),
  .last_res      (out.last_res),
  .span_error    (out.span_error),
  .items_dropped (out.items_dropped)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives runs of signed values into the stable counting sort and checks
// every result beat against a predictor kept in the bench. A short table of
// directed beats comes first (extremes, span limits, duplicates), followed by
// random runs of narrow, wide and over-capacity length, with random gaps on
// both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS  = 64;
  localparam int COUNT_BINS = 256;
  localparam int VALUE_BITS = 16;
  localparam int DIRECTED_N = 21;
  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [15:0] sorted_value;
    logic               last_res;
    logic               span_error;
    logic               items_dropped;
  } sort_result_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
    logic               typed;
    sort_result_t       want;
  } stim_row_t;

  logic clk;
  logic rst;

  csort_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  csort_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch ();

  counting_sort_stable #(
    .MAX_ITEMS (MAX_ITEMS),
    .COUNT_BINS(COUNT_BINS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in (in_ch),
    .out(out_ch)
  );

  // predictor state
  logic signed [15:0] stored_vals [MAX_ITEMS];
  logic signed [15:0] placed_vals [MAX_ITEMS];
  int                 bin_hist [COUNT_BINS];
  int                 stored_n;
  logic signed [15:0] run_lo;
  logic signed [15:0] run_hi;
  logic               run_dropped;

  sort_result_t run_results [$];
  sort_result_t pending_results [$];
  stim_row_t    directed_rows [DIRECTED_N];

  int error_count = 0;
  bit hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL counting_sort_stable");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void reset_run_state();
    foreach (bin_hist[i]) bin_hist[i] = 0;
    stored_n    = 0;
    run_lo      = 16'sh7fff;
    run_hi      = 16'sh8000;
    run_dropped = 1'b0;
  endfunction

  // stable counting sort of the stored run; results land in run_results
  task automatic sort_predict(input logic signed [15:0] v, input logic is_last);
    int span;
    int b;
    sort_result_t r;
    run_results.delete();
    if (stored_n < MAX_ITEMS) begin
      stored_vals[stored_n] = v;
      stored_n++;
      if (v < run_lo) run_lo = v;
      if (v > run_hi) run_hi = v;
    end else begin
      run_dropped = 1'b1;
    end
    if (!is_last) return;
    span = int'(run_hi) - int'(run_lo) + 1;
    if (span > COUNT_BINS) begin
      r = '{sorted_value: '0, last_res: 1'b1, span_error: 1'b1, items_dropped: run_dropped};
      run_results = {run_results, r};
    end else begin
      for (int i = 0; i < stored_n; i++) begin
        b = int'(stored_vals[i]) - int'(run_lo);
        bin_hist[b]++;
      end
      for (int i = 1; i < span; i++) bin_hist[i] += bin_hist[i-1];
      for (int i = stored_n - 1; i >= 0; i--) begin
        b = int'(stored_vals[i]) - int'(run_lo);
        bin_hist[b]--;
        placed_vals[bin_hist[b]] = stored_vals[i];
      end
      for (int i = 0; i < stored_n; i++) begin
        r = '{sorted_value: placed_vals[i], last_res: (i == stored_n - 1),
              span_error: 1'b0, items_dropped: run_dropped};
        run_results = {run_results, r};
      end
    end
    reset_run_state();
  endtask

  task automatic send_beat(input logic signed [15:0] v, input logic lst, input logic typed,
                           input sort_result_t want, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sort_predict(v, lst);
    if (typed) begin
      if (run_results.size() != 1)
        report_mismatch($sformatf("directed beat %0d expects one result", v));
      pending_results = {pending_results, want};
    end else begin
      foreach (run_results[i]) pending_results = {pending_results, run_results[i]};
    end
  endtask

  function automatic int pick_gap(input bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 2);
  endfunction

  task automatic random_run(input int run_no, inout int sent);
    int len;
    int mode;
    int spread;
    int base;
    bit burst;
    logic signed [15:0] v;
    if (run_no == 1) len = MAX_ITEMS;
    else if (run_no == 5) len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
    else len = $urandom_range(1, 10);
    mode   = $urandom_range(0, 9);
    spread = ($urandom_range(0, 3) == 0) ? COUNT_BINS - 1 : $urandom_range(0, 40);
    if (mode == 9) spread = $urandom_range(COUNT_BINS - 1, COUNT_BINS + 40);
    base = $urandom_range(0, 65535 - spread) - 32768;
    if (mode == 8) base = $urandom_range(0, 1) ? -32768 : 32767 - spread;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (mode == 6 || mode == 7) v = 16'($urandom);
      else v = 16'(base + $urandom_range(0, spread));
      send_beat(v, (i == len - 1), 1'b0, '0, pick_gap(burst));
      sent++;
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int off;
    int on;
    out_ch.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        off = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        if (off > 0) begin
          out_ch.ready <= 1'b0;
          repeat (off) @(posedge clk);
        end
      end
      on = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (on) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    sort_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat value %0d", out_ch.sorted_value));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.sorted_value !== want.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, want %0d",
                                    out_ch.sorted_value, want.sorted_value));
        if (out_ch.last_res !== want.last_res)
          report_mismatch($sformatf("last_res %b, want %b", out_ch.last_res, want.last_res));
        if (out_ch.span_error !== want.span_error)
          report_mismatch($sformatf("span_error %b, want %b",
                                    out_ch.span_error, want.span_error));
        if (out_ch.items_dropped !== want.items_dropped)
          report_mismatch($sformatf("items_dropped %b, want %b",
                                    out_ch.items_dropped, want.items_dropped));
      end
    end
  end

  initial begin
    int sent;
    int run_no;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    reset_run_state();
    directed_rows = '{
      '{16'sd0,      1'b1, 1'b1, '{16'sd0,      1'b1, 1'b0, 1'b0}},
      '{16'sh7fff,   1'b1, 1'b1, '{16'sh7fff,   1'b1, 1'b0, 1'b0}},
      '{16'sh8000,   1'b1, 1'b1, '{16'sh8000,   1'b1, 1'b0, 1'b0}},
      '{16'sh8000,   1'b0, 1'b0, '0},
      '{16'sh7fff,   1'b1, 1'b1, '{16'sd0,      1'b1, 1'b1, 1'b0}},
      '{16'sd5,      1'b0, 1'b0, '0},
      '{-16'sd3,     1'b0, 1'b0, '0},
      '{16'sd5,      1'b0, 1'b0, '0},
      '{16'sd0,      1'b0, 1'b0, '0},
      '{-16'sd3,     1'b1, 1'b0, '0},
      '{-16'sd128,   1'b0, 1'b0, '0},
      '{16'sd127,    1'b1, 1'b0, '0},
      '{-16'sd128,   1'b0, 1'b0, '0},
      '{16'sd128,    1'b1, 1'b1, '{16'sd0,      1'b1, 1'b1, 1'b0}},
      '{16'sd7,      1'b0, 1'b0, '0},
      '{16'sd7,      1'b0, 1'b0, '0},
      '{16'sd7,      1'b1, 1'b0, '0},
      '{16'sh5555,   1'b0, 1'b0, '0},
      '{16'shaaaa,   1'b1, 1'b1, '{16'sd0,      1'b1, 1'b1, 1'b0}},
      '{-16'sd1,     1'b0, 1'b0, '0},
      '{16'sd0,      1'b1, 1'b0, '0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want, $urandom_range(0, 3));

    hold_pending = 1'b1;
    sent   = 0;
    run_no = 0;
    while (sent < RANDOM_ITEMS) begin
      random_run(run_no, sent);
      run_no++;
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("PASS counting_sort_stable");
    else
      $display("FAIL counting_sort_stable");
    $finish;
  end

endmodule
